[rtl/core/hsvrgb_pkg.sv]
// Package for the HSV to RGB converter: sector codes, stage enable bundle and
// the fixed constants of the integer conversion. Depends on nothing.
package hsvrgb_pkg;

	localparam int unsigned HUE_W = 9;
	localparam int unsigned PCT_W = 7;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned REM_W = 6;

	localparam int unsigned HUE_MAX = 359;
	localparam int unsigned PCT_MAX = 100;
	localparam int unsigned SECTOR_DEG = 60;

	// 6000 - k * s is the scaled complement that every channel multiplies by V.
	localparam int unsigned FULL_D = 6000;
	localparam int unsigned D_W = 13;
	localparam int unsigned VD_W = 20;

	// 255 / 600000 reduces to 17 / 40000 = 17 / (64 * 625). The division by 625
	// is a multiplication by ceil(2^28 / 625), exact for every operand below 2^19.
	localparam int unsigned RECIP_M = 429497;
	localparam int unsigned RECIP_SHIFT = 28;
	localparam int unsigned RECIP_W = 19;

	typedef enum logic [2:0] {
		SEC_RED_YELLOW,
		SEC_YELLOW_GREEN,
		SEC_GREEN_CYAN,
		SEC_CYAN_BLUE,
		SEC_BLUE_MAGENTA,
		SEC_MAGENTA_RED
	} sector_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

[rtl/core/hsvrgb_if.sv]
// Stream interfaces of the HSV to RGB converter: HSV input beats and RGB
// result beats, each with valid and ready. Depends on nothing.
interface hsvrgb_hsv_if;
	logic       valid;
	logic       ready;
	logic [8:0] hue;
	logic [6:0] saturation;
	logic [6:0] value;

	modport source (output valid, output hue, output saturation, output value, input ready);
	modport sink (input valid, input hue, input saturation, input value, output ready);
endinterface

interface hsvrgb_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

[rtl/core/hsv_to_rgb_converter_core.sv]
// Top level of the HSV to RGB converter: pipeline control, four channel
// units and the sector select. Depends on hsvrgb_pkg, hsvrgb_if.sv,
// hsvrgb_sector and hsvrgb_chan.

// The converter takes one HSV beat (hue in degrees 0..360, saturation and value
// in percent 0..100) and returns one RGB beat of three 8-bit channels, computed
// exactly in integers as floor(255 * V * (6000 - k * S) / 600000) for the
// usual v, p, q and t terms. A hue of zero is treated as one degree, a hue above
// 359 as 359, and saturation or value above 100 as 100. The block is a
// five-stage pipeline: clamp and sector split, the k * S product, the V
// multiply, the constant division by a reciprocal multiply, and the output
// register that holds the selected channels. It accepts one beat in every
// clock cycle while the output side is ready; a result waits in the output
// register until taken. Each stage carries its own valid bit and loads
// whenever it is empty or the stage after it moves, so a stalled output only
// backs up the stages that hold data and empty slots fill up meanwhile. The
// block holds no state across beats and reset only clears the valid bits.
module hsv_to_rgb_converter_core (
	input  logic clk,
	input  logic arst_n,
	hsvrgb_hsv_if.sink   hsv,
	hsvrgb_rgb_if.source rgb
);
	import hsvrgb_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	stage_en_t chan_en;

	sector_t          sector_s1, sector_s2, sector_s3, sector_s4;
	logic [REM_W-1:0] rem_s1;
	logic [PCT_W-1:0] sat_s1;
	logic [PCT_W-1:0] val_s1;
	logic [REM_W-1:0] k_t;

	logic [CHAN_W-1:0] cv_s4, cp_s4, cq_s4, ct_s4;
	logic [CHAN_W-1:0] red_s5, green_s5, blue_s5;
	logic [CHAN_W-1:0] red_d, green_d, blue_d;

	// A stage may load when it is empty or when its content moves on.
	assign rdy_s5 = !vld_s5 || rgb.ready;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign hsv.ready = rdy_s1;

	assign chan_en.s2 = rdy_s2;
	assign chan_en.s3 = rdy_s3;
	assign chan_en.s4 = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= hsv.valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	hsvrgb_sector u_sector (
		.clk        (clk),
		.en         (rdy_s1),
		.hue        (hsv.hue),
		.saturation (hsv.saturation),
		.value      (hsv.value),
		.sector_s1  (sector_s1),
		.rem_s1     (rem_s1),
		.sat_s1     (sat_s1),
		.val_s1     (val_s1)
	);

	// The k factor is zero for v, sixty for p, the remainder for q and its
	// complement to sixty for t.
	assign k_t = REM_W'(SECTOR_DEG) - rem_s1;

	hsvrgb_chan u_chan_v (
		.clk (clk), .en (chan_en), .val (val_s1), .sat (sat_s1),
		.k ('0), .chan_s4 (cv_s4)
	);

	hsvrgb_chan u_chan_p (
		.clk (clk), .en (chan_en), .val (val_s1), .sat (sat_s1),
		.k (REM_W'(SECTOR_DEG)), .chan_s4 (cp_s4)
	);

	hsvrgb_chan u_chan_q (
		.clk (clk), .en (chan_en), .val (val_s1), .sat (sat_s1),
		.k (rem_s1), .chan_s4 (cq_s4)
	);

	hsvrgb_chan u_chan_t (
		.clk (clk), .en (chan_en), .val (val_s1), .sat (sat_s1),
		.k (k_t), .chan_s4 (ct_s4)
	);

	// The sector code rides alongside the channel arithmetic.
	always_ff @(posedge clk) begin
		if (rdy_s2) sector_s2 <= sector_s1;
		if (rdy_s3) sector_s3 <= sector_s2;
		if (rdy_s4) sector_s4 <= sector_s3;
	end

	// Standard HSV assignment of v, p, q and t to red, green and blue.
	always_comb begin
		case (sector_s4)
			SEC_RED_YELLOW: begin
				red_d = cv_s4; green_d = ct_s4; blue_d = cp_s4;
			end
			SEC_YELLOW_GREEN: begin
				red_d = cq_s4; green_d = cv_s4; blue_d = cp_s4;
			end
			SEC_GREEN_CYAN: begin
				red_d = cp_s4; green_d = cv_s4; blue_d = ct_s4;
			end
			SEC_CYAN_BLUE: begin
				red_d = cp_s4; green_d = cq_s4; blue_d = cv_s4;
			end
			SEC_BLUE_MAGENTA: begin
				red_d = ct_s4; green_d = cp_s4; blue_d = cv_s4;
			end
			default: begin
				red_d = cv_s4; green_d = cp_s4; blue_d = cq_s4;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			red_s5   <= red_d;
			green_s5 <= green_d;
			blue_s5  <= blue_d;
		end
	end

	assign rgb.valid = vld_s5;
	assign rgb.red   = red_s5;
	assign rgb.green = green_s5;
	assign rgb.blue  = blue_s5;

endmodule

[rtl/core/hsvrgb_sector.sv]
// First pipeline stage: clamps the inputs and splits the hue into sector and
// remainder. Depends on hsvrgb_pkg.
module hsvrgb_sector (
	input  logic                clk,
	input  logic                en,
	input  logic [8:0]          hue,
	input  logic [6:0]          saturation,
	input  logic [6:0]          value,
	output hsvrgb_pkg::sector_t sector_s1,
	output logic [5:0]          rem_s1,
	output logic [6:0]          sat_s1,
	output logic [6:0]          val_s1
);
	import hsvrgb_pkg::*;

	logic [HUE_W-1:0] hue_c;
	logic [PCT_W-1:0] sat_c;
	logic [PCT_W-1:0] val_c;
	sector_t          sector;
	logic [HUE_W-1:0] base;

	always_comb begin
		if (hue == '0) begin
			hue_c = HUE_W'(1);
		end else if (hue > HUE_W'(HUE_MAX)) begin
			hue_c = HUE_W'(HUE_MAX);
		end else begin
			hue_c = hue;
		end
		sat_c = (saturation > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : saturation;
		val_c = (value > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : value;
	end

	// Five threshold compares replace the division by sixty.
	always_comb begin
		if (hue_c >= HUE_W'(5 * SECTOR_DEG)) begin
			sector = SEC_MAGENTA_RED;
		end else if (hue_c >= HUE_W'(4 * SECTOR_DEG)) begin
			sector = SEC_BLUE_MAGENTA;
		end else if (hue_c >= HUE_W'(3 * SECTOR_DEG)) begin
			sector = SEC_CYAN_BLUE;
		end else if (hue_c >= HUE_W'(2 * SECTOR_DEG)) begin
			sector = SEC_GREEN_CYAN;
		end else if (hue_c >= HUE_W'(SECTOR_DEG)) begin
			sector = SEC_YELLOW_GREEN;
		end else begin
			sector = SEC_RED_YELLOW;
		end
	end

	always_comb begin
		case (sector)
			SEC_RED_YELLOW:   base = '0;
			SEC_YELLOW_GREEN: base = HUE_W'(SECTOR_DEG);
			SEC_GREEN_CYAN:   base = HUE_W'(2 * SECTOR_DEG);
			SEC_CYAN_BLUE:    base = HUE_W'(3 * SECTOR_DEG);
			SEC_BLUE_MAGENTA: base = HUE_W'(4 * SECTOR_DEG);
			default:          base = HUE_W'(5 * SECTOR_DEG);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sector_s1 <= sector;
			rem_s1    <= REM_W'(hue_c - base);
			sat_s1    <= sat_c;
			val_s1    <= val_c;
		end
	end

endmodule

[rtl/core/hsvrgb_chan.sv]
// Three-stage arithmetic for one candidate channel value,
// floor(255 * V * (6000 - k * S) / 600000). Depends on hsvrgb_pkg.
module hsvrgb_chan (
	input  logic                  clk,
	input  hsvrgb_pkg::stage_en_t en,
	input  logic [6:0]            val,
	input  logic [6:0]            sat,
	input  logic [5:0]            k,
	output logic [7:0]            chan_s4
);
	import hsvrgb_pkg::*;

	localparam int unsigned X_W = VD_W + 5;
	localparam int unsigned PROD_W = RECIP_W + RECIP_W;

	logic [D_W-1:0]    d_s2;
	logic [PCT_W-1:0]  val_s2;
	logic [VD_W-1:0]   vd_s3;
	logic [X_W-1:0]    x;
	logic [RECIP_W-1:0] y;
	logic [PROD_W-1:0] prod;

	// 17 * vd, then the division by 64 is a shift.
	assign x = (X_W'(vd_s3) << 4) + X_W'(vd_s3);
	assign y = x[X_W-1:6];
	assign prod = PROD_W'(y) * PROD_W'(RECIP_M);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			d_s2   <= D_W'(FULL_D) - D_W'(D_W'(k) * D_W'(sat));
			val_s2 <= val;
		end
		if (en.s3) begin
			vd_s3 <= VD_W'(val_s2) * VD_W'(d_s2);
		end
		if (en.s4) begin
			chan_s4 <= prod[RECIP_SHIFT +: CHAN_W];
		end
	end

endmodule

[tb/sv/hsv_to_rgb_converter_core_tb.sv]
// Self-checking testbench for the HSV to RGB converter core: directed corner beats, then
// random streams under varied input gaps and output stalls. Depends on hsvrgb_pkg,
// the hsvrgb_hsv_if and hsvrgb_rgb_if interfaces and hsv_to_rgb_converter_core.
module hsv_to_rgb_converter_core_tb;
	import hsvrgb_pkg::*;

	// The scale of every channel: floor(255 * V * (6000 - k * S) / 600000).
	localparam int unsigned CHAN_FULL = 255;
	localparam int unsigned SCALE_DIV = 600000;

	// Random beats per stimulus phase; four phases cover every mix of idling.
	localparam int unsigned PHASE_BEATS = 350;
	// Cycles to watch for stray results once every expected pixel has arrived.
	localparam int unsigned DRAIN_CYCLES = 12;
	// Hard stop. The slowest legal run is roughly 1425 beats, i.e. under 300k time units;
	// this leaves a wide margin.
	localparam int unsigned RUN_LIMIT = 2000000;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_px_t;

	// Holds the predicted pixels in arrival order and compares each RGB beat with the
	// oldest one. The conversion itself is done here as well, in plain integers.
	class hsv_rgb_scoreboard;
		rgb_px_t     expected_px[$];
		int unsigned mismatches;
		int unsigned hsv_beats;
		int unsigned rgb_beats;

		// One channel term; k is 0 for v, 60 for p, the remainder for q, 60 - rem for t.
		function logic [CHAN_W-1:0] scale_chan(int unsigned v, int unsigned s, int unsigned k);
			int unsigned num;
			num = CHAN_FULL * v * (FULL_D - k * s);
			return CHAN_W'(num / SCALE_DIV);
		endfunction

		function rgb_px_t convert(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
				logic [PCT_W-1:0] val);
			int unsigned       h;
			int unsigned       s;
			int unsigned       v;
			int unsigned       rem;
			sector_t           sec;
			logic [CHAN_W-1:0] cv;
			logic [CHAN_W-1:0] cp;
			logic [CHAN_W-1:0] cq;
			logic [CHAN_W-1:0] ct;
			rgb_px_t           px;
			h = hue;
			s = sat;
			v = val;
			// Hue zero counts as one degree; everything past 359 is pinned to 359.
			if (h == 0) h = 1;
			if (h > HUE_MAX) h = HUE_MAX;
			if (s > PCT_MAX) s = PCT_MAX;
			if (v > PCT_MAX) v = PCT_MAX;
			sec = sector_t'(h / SECTOR_DEG);
			rem = h % SECTOR_DEG;
			cv = scale_chan(v, s, 0);
			cp = scale_chan(v, s, SECTOR_DEG);
			cq = scale_chan(v, s, rem);
			ct = scale_chan(v, s, SECTOR_DEG - rem);
			case (sec)
				SEC_RED_YELLOW:   px = {cv, ct, cp};
				SEC_YELLOW_GREEN: px = {cq, cv, cp};
				SEC_GREEN_CYAN:   px = {cp, cv, ct};
				SEC_CYAN_BLUE:    px = {cp, cq, cv};
				SEC_BLUE_MAGENTA: px = {ct, cp, cv};
				default:          px = {cv, cp, cq};
			endcase
			return px;
		endfunction

		function void note_hsv(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
				logic [PCT_W-1:0] val);
			expected_px = {expected_px, convert(hue, sat, val)};
			hsv_beats++;
		endfunction

		function void compare_chan(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_rgb(rgb_px_t got);
			rgb_px_t want;
			if (expected_px.size() == 0) begin
				$error("RGB beat with nothing pending: red %0d green %0d blue %0d",
					got.red, got.green, got.blue);
				mismatches++;
				return;
			end
			want = expected_px.pop_front();
			rgb_beats++;
			compare_chan("red", want.red, got.red);
			compare_chan("green", want.green, got.green);
			compare_chan("blue", want.blue, got.blue);
		endfunction

		function int unsigned pending();
			return expected_px.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	hsvrgb_hsv_if hsv_bus ();
	hsvrgb_rgb_if rgb_bus ();

	hsv_to_rgb_converter_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv_bus),
		.rgb    (rgb_bus)
	);

	hsv_rgb_scoreboard color_board = new();

	// Percent chance of a gap after an input beat and of a stall before an output cycle.
	// Each stimulus phase sets them; zero means that side streams back to back.
	int unsigned in_gap_pct    = 0;
	int unsigned out_stall_pct = 0;
	int unsigned clamped_beats = 0;

	// Hues at both ends of every sector plus the clamped values at zero and past 359.
	int unsigned boundary_hues[] = '{0, 1, 59, 60, 119, 120, 179, 180, 239, 240,
		299, 300, 359, 360, 361, 511};

	always #1 clk = ~clk;

	// Mostly short idle stretches, now and then a long one.
	function automatic int unsigned gap_len();
		return ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
	endfunction

	// Puts one HSV beat on the bus and returns at the edge where it is taken. Valid is
	// left high, so the next beat can follow in the very next cycle.
	task automatic send_hsv(input logic [HUE_W-1:0] h, input logic [PCT_W-1:0] s,
			input logic [PCT_W-1:0] v);
		hsv_bus.valid      <= 1'b1;
		hsv_bus.hue        <= h;
		hsv_bus.saturation <= s;
		hsv_bus.value      <= v;
		if (h == 0 || h > HUE_MAX || s > PCT_MAX || v > PCT_MAX) clamped_beats++;
		do @(posedge clk); while (!hsv_bus.ready);
	endtask

	// Sends one beat and then, depending on the current phase, drops valid for a while.
	// The payload is scrambled during the gap so the block cannot lean on stale fields.
	task automatic send_paced(input logic [HUE_W-1:0] h, input logic [PCT_W-1:0] s,
			input logic [PCT_W-1:0] v);
		int unsigned gap;
		send_hsv(h, s, v);
		if ($urandom_range(99) < in_gap_pct) begin
			gap = gap_len();
			hsv_bus.valid      <= 1'b0;
			hsv_bus.hue        <= HUE_W'($urandom);
			hsv_bus.saturation <= PCT_W'($urandom);
			hsv_bus.value      <= PCT_W'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random pixel: mostly legal ranges, with a share of out-of-range fields that the
	// block has to clamp, and a few pinned to the extremes.
	task automatic send_random_hsv();
		logic [HUE_W-1:0] h;
		logic [PCT_W-1:0] s;
		logic [PCT_W-1:0] v;
		h = ($urandom_range(6) == 0) ? HUE_W'($urandom_range(511)) : HUE_W'($urandom_range(360));
		s = ($urandom_range(6) == 0) ? PCT_W'($urandom_range(127)) : PCT_W'($urandom_range(100));
		v = ($urandom_range(6) == 0) ? PCT_W'($urandom_range(127)) : PCT_W'($urandom_range(100));
		if ($urandom_range(19) == 0) s = ($urandom_range(1) == 0) ? PCT_W'(0) : PCT_W'(PCT_MAX);
		if ($urandom_range(19) == 0) v = ($urandom_range(1) == 0) ? PCT_W'(0) : PCT_W'(PCT_MAX);
		send_paced(h, s, v);
	endtask

	// Both handshakes are sampled at the rising edge, before any of that edge's
	// nonblocking updates land, so the monitors see exactly what the block saw.
	always @(posedge clk) begin
		if (arst_n && hsv_bus.valid && hsv_bus.ready)
			color_board.note_hsv(hsv_bus.hue, hsv_bus.saturation, hsv_bus.value);
		if (arst_n && rgb_bus.valid && rgb_bus.ready)
			color_board.check_rgb({rgb_bus.red, rgb_bus.green, rgb_bus.blue});
	end

	// Result side: ready stays high unless the current phase asks for stalls, in which
	// case it drops for a random stretch before a cycle of readiness.
	initial begin
		rgb_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(99) < out_stall_pct) begin
				rgb_bus.ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
			rgb_bus.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Main stimulus: reset, directed corners, then four random phases that walk through
	// no idling, input gaps only, output stalls only and both at once.
	initial begin
		arst_n             <= 1'b0;
		hsv_bus.valid      <= 1'b0;
		hsv_bus.hue        <= '0;
		hsv_bus.saturation <= '0;
		hsv_bus.value      <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every sector boundary and the hue clamps at full saturation and value.
		foreach (boundary_hues[i])
			send_paced(HUE_W'(boundary_hues[i]), PCT_W'(PCT_MAX), PCT_W'(PCT_MAX));
		// Saturation and value at zero, full scale and past full scale, which clamps.
		send_paced(9'd45, 7'd0, 7'd100);
		send_paced(9'd45, 7'd100, 7'd0);
		send_paced(9'd200, 7'd127, 7'd127);
		send_paced(9'd280, 7'd101, 7'd101);
		send_paced(9'd330, 7'd0, 7'd0);
		send_paced(9'd90, 7'd1, 7'd1);
		send_paced(9'd150, 7'd99, 7'd127);
		send_paced(9'd510, 7'd127, 7'd50);
		send_paced(9'd256, 7'd50, 7'd99);

		for (int ph = 0; ph < 4; ph++) begin
			in_gap_pct    = ph[0] ? 30 : 0;
			out_stall_pct = ph[1] ? 30 : 0;
			repeat (PHASE_BEATS) send_random_hsv();
		end
		hsv_bus.valid <= 1'b0;
		// One more edge so the monitor has surely noted the last accepted beat.
		@(posedge clk);

		// Drain the pipeline, then keep watching for a while in case anything extra
		// comes out after the last expected pixel.
		while (color_board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d HSV beats (%0d with clamped fields) and checked %0d RGB beats.",
			color_board.hsv_beats, clamped_beats, color_board.rgb_beats);
		$display("Phases covered back-to-back streaming, input gaps, output stalls and both.");
		if (color_board.mismatches == 0 && color_board.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog in case a handshake never completes.
	initial begin
		#RUN_LIMIT;
		$display("Timed out with %0d pixels still pending.", color_board.pending());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[hsv_to_rgb_converter_core.f]
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_if.sv
rtl/core/hsvrgb_sector.sv
rtl/core/hsvrgb_chan.sv
rtl/core/hsv_to_rgb_converter_core.sv
tb/sv/hsv_to_rgb_converter_core_tb.sv
